@@ sv/aep_pkg.sv @@
`default_nettype none

package aep_pkg;

  // default accumulator width
  localparam int unsigned AepNumWidth = 16;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_SINK_ATTACHED   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTRODUCER_CODE = 1'd1;

  // configuration reset values
  localparam logic [7:0] IntroducerReset = 8'd27;

  // character codes
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_QMARK = 8'h3F;
  localparam logic [7:0] CHR_SEMI  = 8'h3B;
  localparam logic [7:0] CHR_J     = 8'h4A;
  localparam logic [7:0] CHR_M     = 8'h6D;
  localparam logic [7:0] CHR_F     = 8'h66;
  localparam logic [7:0] CHR_H     = 8'h68;
  localparam logic [7:0] CHR_L     = 8'h6C;

  // sequence codes
  localparam int unsigned ClearCode  = 2;
  localparam int unsigned CursorCode = 25;
  localparam int unsigned FgLo       = 30;
  localparam int unsigned FgHi       = 37;
  localparam int unsigned FgBrLo     = 90;
  localparam int unsigned FgBrHi     = 97;
  localparam int unsigned BgLo       = 40;
  localparam int unsigned BgHi       = 47;
  localparam int unsigned BgBrLo     = 100;
  localparam int unsigned BgBrHi     = 107;

  // parse state
  typedef enum logic [2:0] {
    ST_TEXT  = 3'd0,
    ST_INTRO = 3'd1,
    ST_NUM1  = 3'd2,
    ST_SEMI  = 3'd3,
    ST_NUM2  = 3'd4,
    ST_QMARK = 3'd5,
    ST_QNUM  = 3'd6
  } aep_state_e;

  // result action codes
  typedef enum logic [2:0] {
    ACT_PRINT  = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_RESET  = 3'd2,
    ACT_FG     = 3'd3,
    ACT_BG     = 3'd4,
    ACT_MOVE   = 3'd5,
    ACT_CURSOR = 3'd6
  } aep_action_e;

  // one result beat
  typedef struct packed {
    aep_action_e action;
    logic [7:0]  print_byte;
    logic [3:0]  color_index;
    logic [15:0] cursor_col;
    logic [15:0] cursor_row;
    logic        cursor_visible;
  } aep_result_t;

endpackage

`default_nettype wire

@@ sv/aep_decode.sv @@
`default_nettype none

module aep_decode
  import aep_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = AepNumWidth
) (
  input  wire logic [7:0]           byte_i,
  input  wire logic [7:0]           intro_i,
  input  wire aep_state_e           state_i,
  input  wire logic [NUM_WIDTH-1:0] first_i,
  input  wire logic [NUM_WIDTH-1:0] second_i,
  output aep_state_e                state_o,
  output logic [NUM_WIDTH-1:0]      first_o,
  output logic [NUM_WIDTH-1:0]      second_o,
  output logic                      emit_o,
  output aep_result_t               result_o
);

  localparam int unsigned ProdW = NUM_WIDTH + 4;
  localparam int unsigned ExtW  = NUM_WIDTH + 16;
  localparam logic [ProdW-1:0] NumMax = ProdW'({NUM_WIDTH{1'b1}});

  // acc * 10 + digit, saturating
  function automatic logic [NUM_WIDTH-1:0] acc_digit(input logic [NUM_WIDTH-1:0] acc,
                                                     input logic [3:0] dig);
    logic [ProdW-1:0] prod;
    prod = (ProdW'(acc) << 3) + (ProdW'(acc) << 1) + ProdW'(dig);
    return (prod > NumMax) ? {NUM_WIDTH{1'b1}} : prod[NUM_WIDTH-1:0];
  endfunction

  // clamp to a 16-bit cursor coordinate
  function automatic logic [15:0] clamp16(input logic [NUM_WIDTH-1:0] v);
    logic [ExtW-1:0] ext;
    ext = ExtW'(v);
    return (ext > ExtW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  logic                 digit_hit;
  logic [3:0]           dig;
  logic                 replay;
  logic [NUM_WIDTH-1:0] code;

  assign digit_hit = (byte_i >= CHR_ZERO) && (byte_i <= CHR_NINE);
  assign dig       = 4'(byte_i - CHR_ZERO);
  assign code      = first_i;

  // next state and result
  always_comb begin
    state_o  = ST_TEXT;
    first_o  = first_i;
    second_o = second_i;
    emit_o   = 1'b0;
    replay   = 1'b0;
    result_o = '0;
    unique case (state_i)
      ST_TEXT: begin
        replay = 1'b1;
      end
      ST_INTRO: begin
        if (digit_hit) begin
          first_o = acc_digit('0, dig);
          state_o = ST_NUM1;
        end else if (byte_i == CHR_QMARK) begin
          state_o = ST_QMARK;
        end else begin
          replay = 1'b1;
        end
      end
      ST_NUM1: begin
        if (digit_hit) begin
          first_o = acc_digit(first_i, dig);
          state_o = ST_NUM1;
        end else if (byte_i == CHR_J) begin
          if (first_i == NUM_WIDTH'(ClearCode)) begin
            emit_o          = 1'b1;
            result_o.action = ACT_CLEAR;
          end
        end else if (byte_i == CHR_M) begin
          // color selection codes
          if (code == '0) begin
            emit_o          = 1'b1;
            result_o.action = ACT_RESET;
          end else if (code >= NUM_WIDTH'(FgLo) && code <= NUM_WIDTH'(FgHi)) begin
            emit_o               = 1'b1;
            result_o.action      = ACT_FG;
            result_o.color_index = 4'(code - NUM_WIDTH'(FgLo));
          end else if (code >= NUM_WIDTH'(FgBrLo) && code <= NUM_WIDTH'(FgBrHi)) begin
            emit_o               = 1'b1;
            result_o.action      = ACT_FG;
            result_o.color_index = 4'(code - NUM_WIDTH'(FgBrLo - 8));
          end else if (code >= NUM_WIDTH'(BgLo) && code <= NUM_WIDTH'(BgHi)) begin
            emit_o               = 1'b1;
            result_o.action      = ACT_BG;
            result_o.color_index = 4'(code - NUM_WIDTH'(BgLo));
          end else if (code >= NUM_WIDTH'(BgBrLo) && code <= NUM_WIDTH'(BgBrHi)) begin
            emit_o               = 1'b1;
            result_o.action      = ACT_BG;
            result_o.color_index = 4'(code - NUM_WIDTH'(BgBrLo - 8));
          end
        end else if (byte_i == CHR_SEMI) begin
          second_o = '0;
          state_o  = ST_SEMI;
        end else begin
          replay = 1'b1;
        end
      end
      ST_SEMI: begin
        if (digit_hit) begin
          second_o = acc_digit('0, dig);
          state_o  = ST_NUM2;
        end else begin
          replay = 1'b1;
        end
      end
      ST_NUM2: begin
        if (digit_hit) begin
          second_o = acc_digit(second_i, dig);
          state_o  = ST_NUM2;
        end else if (byte_i == CHR_F) begin
          emit_o              = 1'b1;
          result_o.action     = ACT_MOVE;
          result_o.cursor_col = clamp16(first_i);
          result_o.cursor_row = clamp16(second_i);
        end else begin
          replay = 1'b1;
        end
      end
      ST_QMARK: begin
        if (digit_hit) begin
          first_o = acc_digit('0, dig);
          state_o = ST_QNUM;
        end else begin
          replay = 1'b1;
        end
      end
      ST_QNUM: begin
        if (digit_hit) begin
          first_o = acc_digit(first_i, dig);
          state_o = ST_QNUM;
        end else if ((byte_i == CHR_H || byte_i == CHR_L) &&
                     first_i == NUM_WIDTH'(CursorCode)) begin
          emit_o                  = 1'b1;
          result_o.action         = ACT_CURSOR;
          result_o.cursor_visible = (byte_i == CHR_H);
        end else begin
          replay = 1'b1;
        end
      end
      default: begin
        // unused state code: drop the byte, back to text
        state_o = ST_TEXT;
      end
    endcase

    // byte handled as text: the introducer opens a sequence, any other byte is printed
    if (replay) begin
      if (byte_i == intro_i) begin
        state_o = ST_INTRO;
      end else begin
        emit_o              = 1'b1;
        result_o            = '0;
        result_o.action     = ACT_PRINT;
        result_o.print_byte = byte_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ansi_escape_parser_unit.sv @@
`default_nettype none

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-----------------------------------------
// in       | input     | in_valid_i/in_stall_o   | in_byte_i
// out      | output    | out_valid_o/out_stall_i | action_o, print_byte_o, color_index_o,
//          |           |                         | cursor_col_o, cursor_row_o, cursor_visible_o
// cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// one byte per cycle sustained while no result beat is held back by a stall
// the byte sits in an input register, decode runs combinationally to the result register
// reset clears parse state, numbers and both valid flags; sink detached, introducer ESC
// a stalled result only holds back bytes that give a result while the sink is attached; others pass through
// no clearing pass after reset

module ansi_escape_parser_unit
  import aep_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = AepNumWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         in_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              action_o,
  output logic [7:0]              print_byte_o,
  output logic [3:0]              color_index_o,
  output logic [15:0]             cursor_col_o,
  output logic [15:0]             cursor_row_o,
  output logic                    cursor_visible_o
);

  logic                 sink_q;
  logic [7:0]           intro_q;
  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_byte_q;
  aep_state_e           state_q, state_d;
  logic [NUM_WIDTH-1:0] first_q, first_d;
  logic [NUM_WIDTH-1:0] second_q, second_d;
  logic                 out_valid_q, out_valid_d;
  aep_result_t          res_q, res_d;
  logic                 emit;
  logic                 out_free;
  logic                 adv;
  logic                 in_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_q  <= 1'b0;
      intro_q <= IntroducerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SINK_ATTACHED:   sink_q  <= cfg_wdata_i[0];
        CFG_INTRODUCER_CODE: intro_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // decode of the registered byte
  aep_decode #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_decode (
    .byte_i  (in_byte_q),
    .intro_i (intro_q),
    .state_i (state_q),
    .first_i (first_q),
    .second_i(second_q),
    .state_o (state_d),
    .first_o (first_d),
    .second_o(second_d),
    .emit_o  (emit),
    .result_o(res_d)
  );

  // flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && (out_free || !(emit && sink_q));
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && emit && sink_q) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_TEXT;
      first_q     <= '0;
      second_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        state_q  <= state_d;
        first_q  <= first_d;
        second_q <= second_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
    if (adv && emit && sink_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_o         = res_q.action;
  assign print_byte_o     = res_q.print_byte;
  assign color_index_o    = res_q.color_index;
  assign cursor_col_o     = res_q.cursor_col;
  assign cursor_row_o     = res_q.cursor_row;
  assign cursor_visible_o = res_q.cursor_visible;

endmodule

`default_nettype wire

@@ sv/aep_checker.sv @@
`default_nettype none

module aep_sva_checker
  import aep_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_stall_i,
  input wire logic [2:0]  action_i,
  input wire logic [7:0]  print_byte_i,
  input wire logic [3:0]  color_index_i,
  input wire logic        cursor_visible_i
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(action_i))
    else $error("result beat dropped or changed under stall");

  // action is a defined code
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> action_i != 3'd7)
    else $error("undefined action code");

  // print byte only carried by print beats
  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i != ACT_PRINT |-> print_byte_i == 8'd0)
    else $error("print byte set on non-print beat");

  // palette index only on color beats
  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i != ACT_FG && action_i != ACT_BG |-> color_index_i == 4'd0)
    else $error("color index set on non-color beat");

  // visibility flag only on cursor beats
  a_vis_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && cursor_visible_i |-> action_i == ACT_CURSOR)
    else $error("cursor visible set on non-cursor beat");

endmodule

bind ansi_escape_parser_unit aep_sva_checker u_aep_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_i        (action_o),
  .print_byte_i    (print_byte_o),
  .color_index_i   (color_index_o),
  .cursor_visible_i(cursor_visible_o)
);

`default_nettype wire
